// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the note event stream parser.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define NESP_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define NESP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: sv/nesp_pkg.sv
// ----------------------------------------------------------------------------
// Note event stream parser package
// Token and result types, result kinds and header constants.
// ----------------------------------------------------------------------------
package nesp_pkg;

  localparam int unsigned HDR_LEN     = 7;
  localparam int unsigned ADDR_W      = 22;
  localparam int unsigned QUEUE_DEPTH = 2;

  // File mark, first byte at index 0
  localparam logic [7:0] MAGIC [HDR_LEN] = '{8'h4D, 8'h41, 8'h33, 8'h76, 8'h30, 8'h31, 8'h02};

  localparam int unsigned NOTE_ON_BIT = 7;
  localparam int unsigned BEND_BIT    = 6;

  typedef enum logic [2:0] {
    KIND_TABLE    = 3'd0,
    KIND_NOTE_ON  = 3'd1,
    KIND_RAW      = 3'd2,
    KIND_BEND     = 3'd3,
    KIND_NOTE_OFF = 3'd4,
    KIND_TRUNC    = 3'd5
  } kind_e;

  // One byte handed from the header stage to the event stage
  typedef struct packed {
    logic [7:0] data;
    logic       is_match;  // header matched, byte field unused
    logic       clr;       // wipe parse state before this token
    logic       fin;       // last byte of the file
  } token_t;

  typedef struct packed {
    kind_e             kind;
    logic [3:0]        channel;
    logic [15:0]       delay;
    logic [15:0]       pitch;
    logic [15:0]       instrument;
    logic [ADDR_W-1:0] ram_address;
    logic [7:0]        data_byte;
    logic              last_of_block;
  } result_t;

endpackage

// File: sv/nesp_front.sv
// ----------------------------------------------------------------------------
// Header stage
// Buffers the file mark, checks it and turns input bytes into tokens,
// replaying the buffered bytes on a mismatch or a short file.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nesp_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [7:0]       stream_byte_i,
  input  logic             first_byte_i,
  input  logic             final_byte_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             fifo_full_i,
  output logic             tok_push_o,
  output nesp_pkg::token_t tok_o
);

  typedef enum logic [1:0] {ST_HDR, ST_PASS, ST_REPLAY} state_e;

  state_e     state_q, state_d;
  logic [2:0] hcnt_q, hcnt_d;
  logic [2:0] rlen_q, rlen_d;
  logic [2:0] ridx_q, ridx_d;
  logic       rfin_q, rfin_d;
  logic       pend_q, pend_d;
  logic [7:0] hbuf_q [nesp_pkg::HDR_LEN];

  logic       accept;
  logic       hdr_path;
  logic       match;
  logic       buf_we;
  logic       replay_last;
  logic [2:0] cnt_eff;

  always_comb begin
    match = (stream_byte_i == nesp_pkg::MAGIC[nesp_pkg::HDR_LEN-1]);
    for (int i = 0; i < nesp_pkg::HDR_LEN - 1; i++) begin
      match = match && (hbuf_q[i] == nesp_pkg::MAGIC[i]);
    end
  end

  always_comb begin
    in_stall_o  = (state_q == ST_REPLAY) || fifo_full_i;
    accept      = in_valid_i && !in_stall_o;
    hdr_path    = (state_q == ST_HDR) || first_byte_i;
    cnt_eff     = first_byte_i ? 3'd0 : hcnt_q;
    replay_last = (ridx_q == rlen_q - 3'd1);

    state_d = state_q;
    hcnt_d  = hcnt_q;
    rlen_d  = rlen_q;
    ridx_d  = ridx_q;
    rfin_d  = rfin_q;
    pend_d  = pend_q;
    buf_we  = 1'b0;

    tok_push_o     = 1'b0;
    tok_o.data     = stream_byte_i;
    tok_o.is_match = 1'b0;
    tok_o.clr      = pend_q || first_byte_i;
    tok_o.fin      = final_byte_i;

    case (state_q)
      ST_REPLAY: begin
        tok_o.data = hbuf_q[ridx_q];
        tok_o.clr  = pend_q;
        tok_o.fin  = rfin_q && replay_last;
        if (!fifo_full_i) begin
          tok_push_o = 1'b1;
          pend_d     = 1'b0;
          ridx_d     = ridx_q + 3'd1;
          if (replay_last) begin
            state_d = rfin_q ? ST_HDR : ST_PASS;
          end
        end
      end
      default: begin
        if (accept) begin
          if (hdr_path) begin
            buf_we = 1'b1;
            if (cnt_eff == 3'(nesp_pkg::HDR_LEN - 1)) begin
              hcnt_d = 3'd0;
              if (match) begin
                tok_push_o     = 1'b1;
                tok_o.is_match = 1'b1;
                pend_d         = 1'b0;
                state_d        = final_byte_i ? ST_HDR : ST_PASS;
              end else begin
                state_d = ST_REPLAY;
                rlen_d  = 3'(nesp_pkg::HDR_LEN);
                ridx_d  = 3'd0;
                rfin_d  = final_byte_i;
                pend_d  = pend_q || first_byte_i;
              end
            end else if (final_byte_i) begin
              // short file: replay what was collected
              state_d = ST_REPLAY;
              rlen_d  = cnt_eff + 3'd1;
              ridx_d  = 3'd0;
              rfin_d  = 1'b1;
              hcnt_d  = 3'd0;
              pend_d  = pend_q || first_byte_i;
            end else begin
              state_d = ST_HDR;
              hcnt_d  = cnt_eff + 3'd1;
              pend_d  = pend_q || first_byte_i;
            end
          end else begin
            tok_push_o = 1'b1;
            pend_d     = 1'b0;
            if (final_byte_i) begin
              state_d = ST_HDR;
              hcnt_d  = 3'd0;
            end
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_HDR;
      hcnt_q  <= 3'd0;
      rlen_q  <= 3'd0;
      ridx_q  <= 3'd0;
      rfin_q  <= 1'b0;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      hcnt_q  <= hcnt_d;
      rlen_q  <= rlen_d;
      ridx_q  <= ridx_d;
      rfin_q  <= rfin_d;
      pend_q  <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (buf_we) begin
      hbuf_q[cnt_eff] <= stream_byte_i;
    end
  end

  `NESP_ASSERT(a_push_room, clk_i, rst_ni, tok_push_o |-> !fifo_full_i, "token pushed into full queue")
  `NESP_ASSERT(a_replay_range, clk_i, rst_ni, (state_q == ST_REPLAY) |-> (ridx_q < rlen_q), "replay index past buffered bytes")

endmodule

// File: sv/nesp_fifo.sv
// ----------------------------------------------------------------------------
// Token queue
// Short register queue that decouples the header and event stages.
// ----------------------------------------------------------------------------
module nesp_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  nesp_pkg::token_t push_data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic             valid_o,
  output nesp_pkg::token_t pop_data_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  nesp_pkg::token_t mem_q [DEPTH];
  logic [PTR_W-1:0] wr_q, rd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             do_push, do_pop;

  assign full_o     = (cnt_q == CNT_W'(DEPTH));
  assign valid_o    = (cnt_q != '0);
  assign pop_data_o = mem_q[rd_q];
  assign do_push    = push_i && !full_o;
  assign do_pop     = pop_i && valid_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (do_push) begin
        wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

endmodule

// File: sv/nesp_back.sv
// ----------------------------------------------------------------------------
// Event stage
// Reads the instrument count, emits table writes and decodes events into
// result items; a truncation item follows when a file ends mid-structure.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nesp_back #(
  parameter int unsigned VOICE_BYTES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [15:0]       cfg_wdata_i,
  input  logic              tok_valid_i,
  input  nesp_pkg::token_t  tok_i,
  output logic              tok_pop_o,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output nesp_pkg::result_t res_o
);

  localparam int unsigned IDX_W = $clog2(VOICE_BYTES + 5);
  localparam int unsigned AW    = nesp_pkg::ADDR_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(VOICE_BYTES + 4);

  typedef enum logic [2:0] {PH_IDLE, PH_COUNT_LO, PH_COUNT_HI, PH_TABLE, PH_EVENTS} phase_e;

  phase_e            phase_q, phase_d, c_phase;
  logic              tm_q, tm_d, c_tm;
  logic [IDX_W-1:0]  idx_q, idx_d, c_idx;
  logic [7:0]        cnt_lo_q, cnt_lo_d;
  logic [AW-1:0]     left_q, left_d;
  logic [AW-1:0]     addr_q, addr_d;
  logic [15:0]       dly_q, dly_d;
  logic [7:0]        chb_q, chb_d;
  logic [15:0]       pitch_q, pitch_d;
  logic [7:0]        ins_lo_q, ins_lo_d;
  logic [15:0]       ram_base_q;
  logic              ov_q, ov_d;
  logic              pend_q, pend_d;
  logic              res_we;
  nesp_pkg::result_t res_q, res_d, res, trunc;

  logic       take, out_free, res_v, unfin;
  logic [7:0] b;

  assign b           = tok_i.data;
  assign out_free    = !ov_q || !out_stall_i;
  assign take        = tok_valid_i && !pend_q && out_free;
  assign tok_pop_o   = take;
  assign out_valid_o = ov_q;
  assign res_o       = res_q;

  always_comb begin
    trunc      = '0;
    trunc.kind = nesp_pkg::KIND_TRUNC;
  end

  // Parse one token
  always_comb begin
    c_phase = tok_i.clr ? PH_IDLE : phase_q;
    c_tm    = tok_i.clr ? 1'b0 : tm_q;
    c_idx   = tok_i.clr ? '0 : idx_q;

    phase_d  = c_phase;
    tm_d     = c_tm;
    idx_d    = c_idx;
    cnt_lo_d = cnt_lo_q;
    left_d   = left_q;
    addr_d   = addr_q;
    dly_d    = dly_q;
    chb_d    = chb_q;
    pitch_d  = pitch_q;
    ins_lo_d = ins_lo_q;
    res      = '0;
    res_v    = 1'b0;
    unfin    = 1'b0;

    if (tok_i.is_match) begin
      phase_d = PH_COUNT_LO;
    end else begin
      case (c_phase)
        PH_COUNT_LO: begin
          cnt_lo_d = b;
          phase_d  = PH_COUNT_HI;
        end
        PH_COUNT_HI: begin
          left_d = AW'({6'd0, b, cnt_lo_q}) * AW'(VOICE_BYTES);
          addr_d = AW'(ram_base_q);
          if (left_d == '0) begin
            tm_d    = 1'b1;
            phase_d = PH_EVENTS;
          end else begin
            phase_d = PH_TABLE;
          end
        end
        PH_TABLE: begin
          res_v           = 1'b1;
          res.kind        = nesp_pkg::KIND_TABLE;
          res.ram_address = addr_q;
          res.data_byte   = b;
          addr_d          = addr_q + AW'(1);
          left_d          = left_q - AW'(1);
          if (left_d == '0) begin
            tm_d    = 1'b1;
            phase_d = PH_EVENTS;
          end
        end
        default: begin
          phase_d     = PH_EVENTS;
          res.delay   = dly_q;
          res.channel = chb_q[3:0];
          if (c_idx == IDX_W'(0)) begin
            dly_d[7:0] = b;
            idx_d      = IDX_W'(1);
          end else if (c_idx == IDX_W'(1)) begin
            dly_d[15:8] = b;
            idx_d       = IDX_W'(2);
          end else if (c_idx == IDX_W'(2)) begin
            chb_d = b;
            if (b[nesp_pkg::NOTE_ON_BIT] || b[nesp_pkg::BEND_BIT]) begin
              idx_d = IDX_W'(3);
            end else begin
              res_v       = 1'b1;
              res.kind    = nesp_pkg::KIND_NOTE_OFF;
              res.channel = b[3:0];
              idx_d       = '0;
            end
          end else begin
            if (c_idx == IDX_W'(3)) begin
              pitch_d[7:0] = b;
            end
            if (c_idx == IDX_W'(4)) begin
              pitch_d[15:8] = b;
            end
            if (c_idx == IDX_W'(5)) begin
              ins_lo_d = b;
            end
            idx_d = c_idx + IDX_W'(1);
            if (chb_q[nesp_pkg::NOTE_ON_BIT] && !c_tm) begin
              // raw voice block, one item per byte
              res_v             = 1'b1;
              res.kind          = nesp_pkg::KIND_RAW;
              res.data_byte     = b;
              res.last_of_block = (c_idx == LAST_IDX);
              if (c_idx == LAST_IDX) begin
                idx_d = '0;
              end
            end else if (chb_q[nesp_pkg::NOTE_ON_BIT]) begin
              if (c_idx == IDX_W'(6)) begin
                res_v          = 1'b1;
                res.kind       = nesp_pkg::KIND_NOTE_ON;
                res.pitch      = pitch_q;
                res.instrument = {b, ins_lo_q};
                idx_d          = '0;
              end
            end else if (c_idx == IDX_W'(4)) begin
              res_v     = 1'b1;
              res.kind  = nesp_pkg::KIND_BEND;
              res.pitch = {b, pitch_q[7:0]};
              idx_d     = '0;
            end
          end
        end
      endcase
    end

    if (tok_i.fin) begin
      unfin = (phase_d == PH_COUNT_LO) || (phase_d == PH_COUNT_HI) ||
              (phase_d == PH_TABLE) || ((phase_d == PH_EVENTS) && (idx_d != '0));
      phase_d = PH_IDLE;
      tm_d    = 1'b0;
      idx_d   = '0;
    end
  end

  // Output register and pending truncation item
  always_comb begin
    ov_d   = ov_q;
    pend_d = pend_q;
    res_we = 1'b0;
    res_d  = res;
    if (take) begin
      if (res_v) begin
        ov_d   = 1'b1;
        res_we = 1'b1;
        pend_d = unfin;
      end else if (unfin) begin
        ov_d   = 1'b1;
        res_we = 1'b1;
        res_d  = trunc;
      end else begin
        ov_d = 1'b0;
      end
    end else if (pend_q && out_free) begin
      ov_d   = 1'b1;
      res_we = 1'b1;
      res_d  = trunc;
      pend_d = 1'b0;
    end else if (ov_q && !out_stall_i) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_IDLE;
      tm_q       <= 1'b0;
      idx_q      <= '0;
      ov_q       <= 1'b0;
      pend_q     <= 1'b0;
      ram_base_q <= 16'd0;
    end else begin
      if (take) begin
        phase_q <= phase_d;
        tm_q    <= tm_d;
        idx_q   <= idx_d;
      end
      ov_q   <= ov_d;
      pend_q <= pend_d;
      if (cfg_we_i) begin
        ram_base_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      cnt_lo_q <= cnt_lo_d;
      left_q   <= left_d;
      addr_q   <= addr_d;
      dly_q    <= dly_d;
      chb_q    <= chb_d;
      pitch_q  <= pitch_d;
      ins_lo_q <= ins_lo_d;
    end
    if (res_we) begin
      res_q <= res_d;
    end
  end

  `NESP_ASSERT(a_pend_held, clk_i, rst_ni, pend_q |-> ov_q, "truncation pending without held item")
  `NESP_ASSERT(a_table_left, clk_i, rst_ni, (phase_q == PH_TABLE) |-> (left_q != '0), "table phase with no bytes left")
  `NESP_ASSERT(a_idx_range, clk_i, rst_ni, idx_q <= LAST_IDX, "event byte index past voice block")
  `NESP_ASSERT_NEXT(a_fin_idle, clk_i, rst_ni, take && tok_i.fin, (phase_q == PH_IDLE) && !tm_q, "parser not idle after final byte")

endmodule

// File: sv/note_event_stream_parser_core.sv
// ----------------------------------------------------------------------------
// Note event stream parser
// Parses a music file byte stream into table writes and note events.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while in_stall_o is low; each result is
// registered in the token queue and the output register. A failed or short
// header check holds off input while buffered bytes replay through the event
// stage, one per cycle if the queue has room. Truncation items can stall it.
// Reset (async, active low) clears all parse state, table mode and ram_base.
module note_event_stream_parser_core #(
  parameter int unsigned VOICE_BYTES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  stream_byte_i,
  input  logic        first_byte_i,
  input  logic        final_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  kind_o,
  output logic [3:0]  channel_o,
  output logic [15:0] delay_o,
  output logic [15:0] pitch_o,
  output logic [15:0] instrument_o,
  output logic [21:0] ram_address_o,
  output logic [7:0]  data_byte_o,
  output logic        last_of_block_o
);

  nesp_pkg::token_t  push_tok, pop_tok;
  nesp_pkg::result_t res;
  logic              push, full, pop, tok_valid;

  nesp_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .stream_byte_i (stream_byte_i),
    .first_byte_i  (first_byte_i),
    .final_byte_i  (final_byte_i),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .fifo_full_i   (full),
    .tok_push_o    (push),
    .tok_o         (push_tok)
  );

  nesp_fifo #(
    .DEPTH (nesp_pkg::QUEUE_DEPTH)
  ) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_tok),
    .full_o      (full),
    .pop_i       (pop),
    .valid_o     (tok_valid),
    .pop_data_o  (pop_tok)
  );

  nesp_back #(
    .VOICE_BYTES (VOICE_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .tok_valid_i (tok_valid),
    .tok_i       (pop_tok),
    .tok_pop_o   (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .res_o       (res)
  );

  assign kind_o          = 3'(res.kind);
  assign channel_o       = res.channel;
  assign delay_o         = res.delay;
  assign pitch_o         = res.pitch;
  assign instrument_o    = res.instrument;
  assign ram_address_o   = res.ram_address;
  assign data_byte_o     = res.data_byte;
  assign last_of_block_o = res.last_of_block;

endmodule
